### hdl/fixed_point_alu_defines.svh
// Assertion macros shared by the fixed-point unit.
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// Immediate implication checked on every rising clock edge outside reset.
`define FPA_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication.
`define FPA_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

### hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Operation codes and the control struct carried down the divider row.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_SUB      = 3'd1,
      OP_MUL      = 3'd2,
      OP_DIV      = 3'd3,
      OP_INT2FIX  = 3'd4,
      OP_FIX2INT  = 3'd5
   } op_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] op;
      logic       no_result;   // result forced to zero, no range check
      logic       div_zero;
      logic       less;
      logic       equal;
   } ctl_type;

endpackage

`default_nettype wire

### hdl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point add, subtract, multiply, divide and conversions.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel: req_type selects the operation, req_operand_a/b give the
//   raw values. One item may be accepted every cycle while req_ready is high.
//   rsp_* channel: one item per request, in order: value, overflow,
//   divide-by-zero and the signed raw compare flags.
//   Every operation passes through one setup stage, one row cell per
//   quotient bit of the restoring divider, and the output register.
//   The divider row holds one item in each cell, so throughput is one item
//   per cycle while the receiver does not stall.
//   All items take the same path so results leave in request order.
//   Reset clears the valid bits of every stage; nothing is pending after it.
//   When the receiver stalls, the whole row holds and req_ready drops until
//   the waiting result is taken; empty slots do not collapse.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_alu_defines.svh"

module fixed_point_alu import fpa_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_type,
   input  wire logic signed [31:0] req_operand_a,
   input  wire logic signed [31:0] req_operand_b,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_result_value,
   output logic                    rsp_overflow,
   output logic                    rsp_divide_by_zero,
   output logic                    rsp_a_less_than_b,
   output logic                    rsp_a_equal_b
);

   localparam int WW = 2 * DATA_WIDTH;
   localparam int NW = DATA_WIDTH + FRAC_BITS;

   logic                  enable;
   ctl_type               ctl   [NW+1];
   logic signed [WW-1:0]  res   [NW+1];
   logic [DATA_WIDTH-1:0] rem   [NW+1];
   logic [NW-1:0]         num   [NW+1];
   logic [NW-1:0]         quo   [NW+1];
   logic [DATA_WIDTH-1:0] den   [NW+1];
   logic                  neg   [NW+1];

   assign enable = rsp_ready || !rsp_valid;
   assign req_ready = enable;
   assign rem[0] = '0;
   assign quo[0] = '0;

   fpa_front #(
      .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .WW(WW), .NW(NW)
   ) u_front (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(req_valid), .in_op(req_type),
      .in_a(req_operand_a), .in_b(req_operand_b),
      .ctl_out(ctl[0]), .res_out(res[0]), .num_out(num[0]),
      .den_out(den[0]), .neg_out(neg[0])
   );

   for (genvar i = 0; i < NW; i++) begin : g_cell
      fpa_div_cell #(.DATA_WIDTH(DATA_WIDTH), .WW(WW), .NW(NW)) u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .ctl_i(ctl[i]), .res_i(res[i]), .rem_i(rem[i]), .num_i(num[i]),
         .quo_i(quo[i]), .den_i(den[i]), .neg_i(neg[i]),
         .ctl_o(ctl[i+1]), .res_o(res[i+1]), .rem_o(rem[i+1]),
         .num_o(num[i+1]), .quo_o(quo[i+1]), .den_o(den[i+1]),
         .neg_o(neg[i+1])
      );
   end

   fpa_back #(
      .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .WW(WW), .NW(NW)
   ) u_back (
      .clock(clock), .reset(reset), .enable(enable),
      .ctl_i(ctl[NW]), .res_i(res[NW]), .quo_i(quo[NW]), .neg_i(neg[NW]),
      .out_valid(rsp_valid), .out_value(rsp_result_value),
      .out_overflow(rsp_overflow), .out_div_zero(rsp_divide_by_zero),
      .out_less(rsp_a_less_than_b), .out_equal(rsp_a_equal_b)
   );

   `FPA_ASSERT_NOW(a_flags_excl, clock, reset, rsp_valid, !(rsp_overflow && rsp_divide_by_zero), "overflow and divide by zero together")
   `FPA_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && (rsp_overflow || rsp_divide_by_zero), rsp_result_value == 32'sd0, "error result not zero")
   `FPA_ASSERT_NOW(a_cmp_excl, clock, reset, rsp_valid, !(rsp_a_less_than_b && rsp_a_equal_b), "less and equal together")
   `FPA_ASSERT_NEXT(a_hold_row, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(ctl[NW]), "row moved while stalled")

endmodule

`default_nettype wire

### hdl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Operand decode, add/sub/shift/multiply and divider setup; one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front import fpa_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 8,
   parameter int WW         = 2 * DATA_WIDTH,
   parameter int NW         = DATA_WIDTH + FRAC_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire logic                   in_valid,
   input  wire logic [2:0]             in_op,
   input  wire logic signed [31:0]     in_a,
   input  wire logic signed [31:0]     in_b,
   output ctl_type                     ctl_out,
   output logic signed [WW-1:0]        res_out,
   output logic [NW-1:0]               num_out,
   output logic [DATA_WIDTH-1:0]       den_out,
   output logic                        neg_out
);

   logic signed [DATA_WIDTH-1:0] a, b;
   logic signed [WW-1:0]         aw, bw, res_in;
   logic [DATA_WIDTH-1:0]        a_abs, b_abs;
   ctl_type                      ctl_in, ctl_ff;
   logic signed [WW-1:0]         res_ff;
   logic [NW-1:0]                num_ff;
   logic [DATA_WIDTH-1:0]        den_ff;
   logic                         neg_ff;

   always_comb begin
      a = in_a[DATA_WIDTH-1:0];
      b = in_b[DATA_WIDTH-1:0];
      aw = WW'(a);
      bw = WW'(b);
      a_abs = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
      b_abs = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : DATA_WIDTH'(b);
      ctl_in.valid = in_valid;
      ctl_in.op = in_op;
      ctl_in.no_result = 1'b0;
      ctl_in.div_zero = 1'b0;
      ctl_in.less = a < b;
      ctl_in.equal = a == b;
      res_in = '0;
      case (in_op)
         OP_ADD:     res_in = aw + bw;
         OP_SUB:     res_in = aw - bw;
         OP_MUL:     res_in = aw * bw;
         OP_DIV: begin
            if (b == '0) begin
               ctl_in.div_zero = 1'b1;
               ctl_in.no_result = 1'b1;
            end
         end
         OP_INT2FIX: res_in = aw <<< FRAC_BITS;
         OP_FIX2INT: res_in = aw >>> FRAC_BITS;
         default:    ctl_in.no_result = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (enable) begin
         ctl_ff.op <= ctl_in.op;
         ctl_ff.no_result <= ctl_in.no_result;
         ctl_ff.div_zero <= ctl_in.div_zero;
         ctl_ff.less <= ctl_in.less;
         ctl_ff.equal <= ctl_in.equal;
         res_ff <= res_in;
         num_ff <= NW'(a_abs) << FRAC_BITS;
         den_ff <= b_abs;
         neg_ff <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      end
   end

   assign ctl_out = ctl_ff;
   assign res_out = res_ff;
   assign num_out = num_ff;
   assign den_out = den_ff;
   assign neg_out = neg_ff;

endmodule

`default_nettype wire

### hdl/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division step; passes the item and its result to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div_cell import fpa_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int WW         = 64,
   parameter int NW         = 40
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire ctl_type                ctl_i,
   input  wire logic signed [WW-1:0]   res_i,
   input  wire logic [DATA_WIDTH-1:0]  rem_i,
   input  wire logic [NW-1:0]          num_i,
   input  wire logic [NW-1:0]          quo_i,
   input  wire logic [DATA_WIDTH-1:0]  den_i,
   input  wire logic                   neg_i,
   output ctl_type                     ctl_o,
   output logic signed [WW-1:0]        res_o,
   output logic [DATA_WIDTH-1:0]       rem_o,
   output logic [NW-1:0]               num_o,
   output logic [NW-1:0]               quo_o,
   output logic [DATA_WIDTH-1:0]       den_o,
   output logic                        neg_o
);

   logic [DATA_WIDTH:0]   trial, diff;
   logic                  qbit;
   ctl_type               ctl_ff;
   logic signed [WW-1:0]  res_ff;
   logic [DATA_WIDTH-1:0] rem_ff, den_ff;
   logic [NW-1:0]         num_ff, quo_ff;
   logic                  neg_ff;

   always_comb begin
      trial = {rem_i, num_i[NW-1]};
      diff = trial - {1'b0, den_i};
      qbit = trial >= {1'b0, den_i};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff.valid <= ctl_i.valid;
      end
      if (enable) begin
         ctl_ff.op <= ctl_i.op;
         ctl_ff.no_result <= ctl_i.no_result;
         ctl_ff.div_zero <= ctl_i.div_zero;
         ctl_ff.less <= ctl_i.less;
         ctl_ff.equal <= ctl_i.equal;
         res_ff <= res_i;
         rem_ff <= qbit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
         num_ff <= num_i << 1;
         quo_ff <= {quo_i[NW-2:0], qbit};
         den_ff <= den_i;
         neg_ff <= neg_i;
      end
   end

   assign ctl_o = ctl_ff;
   assign res_o = res_ff;
   assign rem_o = rem_ff;
   assign num_o = num_ff;
   assign quo_o = quo_ff;
   assign den_o = den_ff;
   assign neg_o = neg_ff;

endmodule

`default_nettype wire

### hdl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Final scaling, range check and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_back import fpa_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 8,
   parameter int WW         = 64,
   parameter int NW         = 40
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire ctl_type                ctl_i,
   input  wire logic signed [WW-1:0]   res_i,
   input  wire logic [NW-1:0]          quo_i,
   input  wire logic                   neg_i,
   output logic                        out_valid,
   output logic signed [31:0]          out_value,
   output logic                        out_overflow,
   output logic                        out_div_zero,
   output logic                        out_less,
   output logic                        out_equal
);

   logic signed [WW-1:0]         r, qw;
   logic signed [DATA_WIDTH-1:0] r_low;
   logic                         fits, ovf;
   logic                         valid_ff, ovf_ff, dbz_ff, less_ff, equal_ff;
   logic signed [31:0]           value_ff;

   always_comb begin
      qw = WW'(quo_i);
      case (ctl_i.op)
         OP_MUL:  r = res_i >>> FRAC_BITS;
         OP_DIV:  r = neg_i ? -qw : qw;
         default: r = res_i;
      endcase
      // in range when all bits above the sign bit match it
      fits = (r[WW-1:DATA_WIDTH-1] == '0) || (r[WW-1:DATA_WIDTH-1] == '1);
      ovf = !ctl_i.no_result && !fits;
      r_low = (ctl_i.no_result || ovf) ? '0 : r[DATA_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= ctl_i.valid;
      end
      if (enable) begin
         value_ff <= 32'(r_low);
         ovf_ff <= ovf;
         dbz_ff <= ctl_i.div_zero;
         less_ff <= ctl_i.less;
         equal_ff <= ctl_i.equal;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_overflow = ovf_ff;
   assign out_div_zero = dbz_ff;
   assign out_less = less_ff;
   assign out_equal = equal_ff;

endmodule

`default_nettype wire
